[rtl/ccc_pkg.sv]
// Shared constants and types for the column pair conflict check.
package ccc_pkg;

    localparam int COLUMNS = 32;
    localparam int ROW_W = 32;
    localparam int CNT_W = 6;
    localparam int EFF_W = $clog2(COLUMNS + 1);

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

    localparam int FLAG_BOTH = 0;
    localparam int FLAG_FIRST = 1;
    localparam int FLAG_SECOND = 2;

    typedef struct packed {
        logic update;
        logic clear;
    } flag_ctrl_t;

endpackage

[rtl/ccc_row_if.sv]
// Handshake channel that carries one matrix row.
interface ccc_row_if;
    logic valid;
    logic ready;
    logic [ccc_pkg::ROW_W-1:0] row_bits;
    logic last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

[rtl/ccc_result_if.sv]
// Handshake channel that carries one check result.
interface ccc_result_if;
    logic valid;
    logic ready;
    logic conflict_free;

    modport source (output valid, output conflict_free, input ready);
    modport sink (input valid, input conflict_free, output ready);
endinterface

[rtl/ccc_pair_flags.sv]
// Sticky gamete flags for every column pair, with per-column conflict summary.
module ccc_pair_flags
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ccc_pkg::flag_ctrl_t              ctrl,
    input  logic [ccc_pkg::COLUMNS-1:0]      col_bits,
    input  logic [ccc_pkg::EFF_W-1:0]        count_eff,
    output logic [ccc_pkg::COLUMNS-1:0]      col_conflict
);

    logic [ccc_pkg::COLUMNS-1:0] pair_hit [ccc_pkg::COLUMNS];

    for (genvar i = 0; i < ccc_pkg::COLUMNS; i++) begin : g_first
        for (genvar j = 0; j < ccc_pkg::COLUMNS; j++) begin : g_second
            if (j > i) begin : g_pair
                logic [2:0] flags_reg;
                logic [2:0] flags_next;
                logic [2:0] seen;
                logic       in_range;

                assign in_range = ccc_pkg::EFF_W'(j) < count_eff;

                always_comb
                begin
                    seen = '0;
                    seen[ccc_pkg::FLAG_BOTH] = col_bits[i] & col_bits[j];
                    seen[ccc_pkg::FLAG_FIRST] = col_bits[i] & ~col_bits[j];
                    seen[ccc_pkg::FLAG_SECOND] = ~col_bits[i] & col_bits[j];
                    flags_next = in_range ? (flags_reg | seen) : flags_reg;
                end

                assign pair_hit[i][j] = in_range & (&flags_next);

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        flags_reg <= '0;
                    end
                    else if (ctrl.update)
                    begin
                        flags_reg <= ctrl.clear ? 3'b000 : flags_next;
                    end
                end
            end
            else begin : g_none
                assign pair_hit[i][j] = 1'b0;
            end
        end
        assign col_conflict[i] = |pair_hit[i];
    end

endmodule

[rtl/column_pair_conflict_check.sv]
// Top level of the column pair conflict check.
//
// Rows enter on row_in, one item per cycle at full rate unless result_out.ready
// stalls the pipeline; every row folds into sticky flags held for each column
// pair, all updated in parallel. An item marked as the last row produces one
// result via the input register, a register holding the per-column conflict
// summary, and the result register. The flags clear when the last row leaves
// the input register, so the next matrix may follow directly. The column count
// is written through cfg_we and cfg_wdata, which the user must do only while no
// item is in flight (unenforced); larger counts act as the full column capacity.
module column_pair_conflict_check
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ccc_pkg::CNT_W-1:0]  cfg_wdata,
    ccc_row_if.sink                    row_in,
    ccc_result_if.source               result_out
);

    logic [ccc_pkg::CNT_W-1:0]   count_reg;
    logic [ccc_pkg::EFF_W-1:0]   count_eff;

    logic                        s1_valid_reg;
    logic [ccc_pkg::ROW_W-1:0]   s1_row_reg;
    logic                        s1_last_reg;

    logic                        s2_valid_reg;
    logic [ccc_pkg::COLUMNS-1:0] s2_conflict_reg;

    logic                        out_valid_reg;
    logic                        conflict_free_reg;

    logic                        out_free;
    logic                        s2_free;
    logic                        s1_move;
    logic                        in_take;

    logic [ccc_pkg::COLUMNS-1:0] col_bits;
    logic [ccc_pkg::COLUMNS-1:0] col_conflict;
    ccc_pkg::flag_ctrl_t         flag_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= ccc_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    assign count_eff = ({1'b0, count_reg} > (ccc_pkg::CNT_W + 1)'(ccc_pkg::COLUMNS))
                     ? ccc_pkg::EFF_W'(ccc_pkg::COLUMNS)
                     : ccc_pkg::EFF_W'(count_reg);

    assign out_free = ~out_valid_reg | result_out.ready;
    assign s2_free = ~s2_valid_reg | out_free;
    assign s1_move = s1_valid_reg & s2_free;
    assign row_in.ready = ~s1_valid_reg | s1_move;
    assign in_take = row_in.valid & row_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (row_in.ready)
        begin
            s1_valid_reg <= row_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_row_reg <= row_in.row_bits;
            s1_last_reg <= row_in.last_row;
        end
    end

    for (genvar c = 0; c < ccc_pkg::COLUMNS; c++) begin : g_col
        if (c < ccc_pkg::ROW_W) begin : g_live
            assign col_bits[c] = s1_row_reg[c];
        end
        else begin : g_zero
            assign col_bits[c] = 1'b0;
        end
    end

    assign flag_ctrl.update = s1_move;
    assign flag_ctrl.clear = s1_last_reg;

    ccc_pair_flags u_pair_flags
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (flag_ctrl),
        .col_bits     (col_bits),
        .count_eff    (count_eff),
        .col_conflict (col_conflict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_move & s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move & s1_last_reg)
        begin
            s2_conflict_reg <= col_conflict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free & s2_valid_reg)
        begin
            conflict_free_reg <= ~(|s2_conflict_reg);
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.conflict_free = conflict_free_reg;

endmodule
